// File: design/source_token_scanner_macros.svh
// Assertion macros used by the result queue module (sts_out)
`ifndef SOURCE_TOKEN_SCANNER_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_MACROS_SVH

// check a property on every rising clock edge outside reset
`define STS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check an implication on every rising clock edge outside reset
`define STS_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

// File: design/sts_pkg.sv
// Types and constants of the source token scanner
package sts_pkg;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_EOL  = 2'd1,
    CMD_EOI  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_NUMBER  = 3'd3,
    MODE_STRING  = 3'd4,
    MODE_STRQ    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    KIND_IDENT  = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_PUNCT  = 3'd2,
    KIND_STRING = 3'd3,
    KIND_STOP   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] tok_char;
    logic       has_char;
    kind_t      kind;
    logic       last;
  } tok_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

endpackage

// File: design/sts_step.sv
// Scanner state and per-word token step
module sts_step
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  cmd_t       cmd,
  input  logic [7:0] ch,
  output logic [1:0] push_n,
  output tok_t       res0,
  output tok_t       res1
);

  mode_t      scan_mode, scan_mode_next;
  logic [7:0] held_char, held_char_next;
  logic       held_valid, held_valid_next;

  logic       is_char, is_letter, is_digit, cont, do_start;
  logic [7:0] folded;
  logic       a_v, b_v;
  tok_t       a_r, b_r;

  always_comb begin
    is_letter = ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ||
                ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) || (ch == CH_UNDER);
    is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    folded    = ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ? (ch & ~CASE_BIT) : ch;
    is_char   = (cmd == CMD_CHAR);
  end

  always_comb begin
    scan_mode_next  = scan_mode;
    held_char_next  = held_char;
    held_valid_next = held_valid;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a_r      = '{tok_char: held_char, has_char: 1'b1, kind: KIND_STRING, last: 1'b0};
    b_r      = '{tok_char: ch, has_char: 1'b1, kind: KIND_PUNCT, last: 1'b1};
    cont     = 1'b0;
    do_start = 1'b0;
    if ((cmd == CMD_CHAR) || (cmd == CMD_EOL) || (cmd == CMD_EOI)) begin
      case (scan_mode)
        MODE_COMMENT: begin
          if (is_char && (ch == CH_RBRACE)) begin
            scan_mode_next = MODE_IDLE;
          end
        end
        MODE_IDENT, MODE_NUMBER: begin
          cont = is_char && ((scan_mode == MODE_IDENT) ? (is_letter || is_digit) : is_digit);
          a_v      = 1'b1;
          a_r.kind = (scan_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
          if (cont) begin
            held_char_next  = (scan_mode == MODE_IDENT) ? folded : ch;
            held_valid_next = 1'b1;
          end else begin
            a_r.last        = 1'b1;
            held_valid_next = 1'b0;
            scan_mode_next  = MODE_IDLE;
            do_start        = is_char;
          end
        end
        MODE_STRING: begin
          if (is_char) begin
            if (ch == CH_QUOTE) begin
              scan_mode_next = MODE_STRQ;
            end else begin
              a_v             = held_valid;
              held_char_next  = ch;
              held_valid_next = 1'b1;
            end
          end else begin
            a_v             = 1'b1;
            a_r.last        = 1'b1;
            a_r.has_char    = held_valid;
            a_r.tok_char    = held_valid ? held_char : 8'h00;
            held_valid_next = 1'b0;
            scan_mode_next  = MODE_IDLE;
          end
        end
        MODE_STRQ: begin
          if (is_char && (ch == CH_QUOTE)) begin
            a_v             = held_valid;
            held_char_next  = CH_QUOTE;
            held_valid_next = 1'b1;
            scan_mode_next  = MODE_STRING;
          end else begin
            a_v             = 1'b1;
            a_r.last        = 1'b1;
            a_r.has_char    = held_valid;
            a_r.tok_char    = held_valid ? held_char : 8'h00;
            held_valid_next = 1'b0;
            scan_mode_next  = MODE_IDLE;
            do_start        = is_char;
          end
        end
        default: begin
          if (is_char) begin
            do_start = 1'b1;
          end else begin
            scan_mode_next = MODE_IDLE;
          end
        end
      endcase

      if (do_start) begin
        held_valid_next = 1'b0;
        if ((ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL)) begin
          scan_mode_next = MODE_IDLE;
        end else if (ch == CH_LBRACE) begin
          scan_mode_next = MODE_COMMENT;
        end else if (is_letter) begin
          held_char_next  = folded;
          held_valid_next = 1'b1;
          scan_mode_next  = MODE_IDENT;
        end else if (is_digit) begin
          held_char_next  = ch;
          held_valid_next = 1'b1;
          scan_mode_next  = MODE_NUMBER;
        end else if (ch == CH_QUOTE) begin
          scan_mode_next = MODE_STRING;
        end else begin
          b_v            = 1'b1;
          scan_mode_next = MODE_IDLE;
        end
      end

      if (cmd == CMD_EOI) begin
        b_v             = 1'b1;
        b_r             = '{tok_char: 8'h00, has_char: 1'b0, kind: KIND_STOP, last: 1'b1};
        scan_mode_next  = MODE_IDLE;
        held_char_next  = 8'h00;
        held_valid_next = 1'b0;
      end
    end
  end

  always_comb begin
    res0   = a_v ? a_r : b_r;
    res1   = b_r;
    push_n = fire ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode  <= MODE_IDLE;
      held_char  <= 8'h00;
      held_valid <= 1'b0;
    end else if (fire) begin
      scan_mode  <= scan_mode_next;
      held_char  <= held_char_next;
      held_valid <= held_valid_next;
    end
  end

endmodule

// File: design/sts_out.sv
// Result queue feeding the output stream
module sts_out
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  tok_t       res0,
  input  tok_t       res1,
  output logic       room,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // tok_char
  output logic [3:0] m_axis_tuser,  // has_char, kind
  output logic       m_axis_tlast
);

  `include "source_token_scanner_macros.svh"

  tok_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr, wptr_next, rptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;
  tok_t             head;

  always_comb begin
    head          = slots[rptr];
    pop           = m_axis_tvalid && m_axis_tready;
    m_axis_tvalid = (count != '0);
    m_axis_tdata  = head.tok_char;
    m_axis_tuser  = {head.kind, head.has_char};
    m_axis_tlast  = head.last;
    room          = (count <= CNT_W'(FIFO_DEPTH - 2));
    wptr_next     = wptr + PTR_W'(1);
    count_next    = count + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slots[wptr] <= res0;
    end
    if (push_n == 2'd2) begin
      slots[wptr_next] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push_n);
      rptr  <= rptr + PTR_W'(pop);
      count <= count_next;
    end
  end

  `STS_CHECK(a_count_bound, count <= CNT_W'(FIFO_DEPTH), "result queue overfilled")
  `STS_CHECK(a_push_bound, push_n != 2'd3, "more than two results for one word")
  `STS_IMPLY(a_push_room, push_n != 2'd0, room, "results pushed without room")
  `STS_CHECK(a_ptr_track, PTR_W'(wptr - rptr) == PTR_W'(count), "queue pointers out of step")

endmodule

// File: design/source_token_scanner.sv
// Top level of the source token scanner
// Takes one word per cycle: s_axis_tuser carries the command (character, end of line,
// end of input) and s_axis_tdata the byte. Each word passes an input register, then
// one combinational scan step updates the scanner state and writes zero, one or two
// result words into a four-entry queue; the output is driven from the queue head.
// A word that yields two results (a token closed by punctuation, or by end of input)
// writes both into the queue at once; the input keeps flowing at one word per cycle until
// the queue holds more than two results. A token's final character is held back until
// the next word shows where it ends.
module source_token_scanner
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // ch
  input  logic [1:0] s_axis_tuser,  // cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // tok_char
  output logic [3:0] m_axis_tuser,  // has_char, kind
  output logic       m_axis_tlast
);

  logic       in_full;
  cmd_t       in_cmd;
  logic [7:0] in_ch;
  logic       room, advance, accept;
  logic [1:0] push_n;
  tok_t       res0, res1;

  always_comb begin
    advance       = in_full && room;
    s_axis_tready = !in_full || advance;
    accept        = s_axis_tvalid && s_axis_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd <= cmd_t'(s_axis_tuser);
      in_ch  <= s_axis_tdata;
    end
  end

  sts_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .cmd    (in_cmd),
    .ch     (in_ch),
    .push_n (push_n),
    .res0   (res0),
    .res1   (res1)
  );

  sts_out u_out (
    .clk           (clk),
    .rst           (rst),
    .push_n        (push_n),
    .res0          (res0),
    .res1          (res1),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the source token scanner: directed and random text, random stalls
module tb;
  import sts_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int RANDOM_WORDS = 650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int CHOKE_AT_A = 200;
  localparam int CHOKE_AT_B = 480;
  localparam int CHOKE_LEN = 300;
  localparam int SRC = 0;
  localparam int SNK = 1;

  typedef enum int {
    PACE_FLAT,
    PACE_SPARSE,
    PACE_BUSY
  } pace_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
  } word_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;  // ch
  logic [1:0] s_axis_tuser = '0;  // cmd
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;       // tok_char
  logic [3:0] m_axis_tuser;       // has_char, kind
  logic       m_axis_tlast;

  word_t pending[$];
  word_t next_word;
  tok_t  tokens_due[$];
  tok_t  want;

  mode_t      scan_mode = MODE_IDLE;
  logic [7:0] held_ch = '0;
  logic       held_ok = 1'b0;

  pace_t pace_style[2];
  int    pace_left[2] = '{0, 0};
  int    src_gap = 0;
  int    snk_wait = 0;
  int    choke_left = 0;
  int    words_in = 0;
  int    words_total = 0;
  int    words_counted = 0;
  int    cycle_count = 0;
  int    mismatches = 0;
  int    random_base;
  logic  word_taken = 1'b0;
  logic  result_taken = 1'b0;

  source_token_scanner dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) || c == CH_UNDER;
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) ? (c & ~CASE_BIT) : c;
  endfunction

  task automatic push_tok(logic [7:0] c, logic has, kind_t k, logic l);
    tok_t t;
    t.tok_char = c;
    t.has_char = has;
    t.kind = k;
    t.last = l;
    tokens_due.push_back(t);
  endtask

  task automatic open_from_idle(logic [7:0] c);
    held_ok = 1'b0;
    if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
      scan_mode = MODE_IDLE;
    end else if (c == CH_LBRACE) begin
      scan_mode = MODE_COMMENT;
    end else if (is_alpha(c)) begin
      held_ch = upcase(c);
      held_ok = 1'b1;
      scan_mode = MODE_IDENT;
    end else if (is_num(c)) begin
      held_ch = c;
      held_ok = 1'b1;
      scan_mode = MODE_NUMBER;
    end else if (c == CH_QUOTE) begin
      scan_mode = MODE_STRING;
    end else begin
      push_tok(c, 1'b1, KIND_PUNCT, 1'b1);
      scan_mode = MODE_IDLE;
    end
  endtask

  task automatic close_string();
    if (held_ok) push_tok(held_ch, 1'b1, KIND_STRING, 1'b1);
    else push_tok(8'h00, 1'b0, KIND_STRING, 1'b1);
    held_ok = 1'b0;
    scan_mode = MODE_IDLE;
  endtask

  // advance the scanner state by one accepted word and queue the tokens it yields
  task automatic scan_word(logic [1:0] cmd, logic [7:0] c);
    kind_t k;
    bit    is_char;
    bit    more;
    is_char = (cmd == CMD_CHAR);
    if (cmd != CMD_NOP) begin
      case (scan_mode)
        MODE_COMMENT: begin
          if (is_char && c == CH_RBRACE) scan_mode = MODE_IDLE;
        end
        MODE_IDENT, MODE_NUMBER: begin
          k = (scan_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
          more = is_char && ((scan_mode == MODE_IDENT) ? (is_alpha(c) || is_num(c)) : is_num(c));
          if (more) begin
            push_tok(held_ch, 1'b1, k, 1'b0);
            held_ch = (scan_mode == MODE_IDENT) ? upcase(c) : c;
            held_ok = 1'b1;
          end else begin
            push_tok(held_ch, 1'b1, k, 1'b1);
            held_ok = 1'b0;
            scan_mode = MODE_IDLE;
            if (is_char) open_from_idle(c);
          end
        end
        MODE_STRING: begin
          if (!is_char) begin
            close_string();
          end else if (c == CH_QUOTE) begin
            scan_mode = MODE_STRQ;
          end else begin
            if (held_ok) push_tok(held_ch, 1'b1, KIND_STRING, 1'b0);
            held_ch = c;
            held_ok = 1'b1;
          end
        end
        MODE_STRQ: begin
          if (is_char && c == CH_QUOTE) begin
            if (held_ok) push_tok(held_ch, 1'b1, KIND_STRING, 1'b0);
            held_ch = CH_QUOTE;
            held_ok = 1'b1;
            scan_mode = MODE_STRING;
          end else begin
            close_string();
            if (is_char) open_from_idle(c);
          end
        end
        default: begin
          if (is_char) open_from_idle(c);
          else scan_mode = MODE_IDLE;
        end
      endcase
      if (cmd == CMD_EOI) begin
        push_tok(8'h00, 1'b0, KIND_STOP, 1'b1);
        scan_mode = MODE_IDLE;
        held_ch = '0;
        held_ok = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(string what, int got, int exp_val);
    mismatches++;
    $display("tb: mismatch on %s: got 0x%0h, expected 0x%0h (cycle %0d)",
             what, got, exp_val, cycle_count);
  endtask

  function automatic int draw_wait(int side);
    if (pace_left[side] == 0) begin
      pace_style[side] = pace_t'($urandom_range(0, 2));
      pace_left[side] = $urandom_range(10, 60);
    end
    pace_left[side]--;
    case (pace_style[side])
      PACE_FLAT: return 0;
      PACE_BUSY: return $urandom_range(0, 11);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
    endcase
  endfunction

  task automatic put(logic [1:0] cmd, logic [7:0] ch);
    word_t w;
    w.cmd = cmd;
    w.ch = ch;
    pending.push_back(w);
    words_total++;
    if (cmd != CMD_NOP) words_counted++;
  endtask

  function automatic logic [7:0] ident_char(bit first);
    case ($urandom_range(0, first ? 2 : 3))
      0: return 8'(CH_LO_A + $urandom_range(0, 25));
      1: return 8'(CH_UP_A + $urandom_range(0, 25));
      2: return CH_UNDER;
      default: return 8'(CH_ZERO + $urandom_range(0, 9));
    endcase
  endfunction

  // queue one random piece of text: mostly well-formed tokens, some noise
  task automatic add_fragment();
    int         pick;
    int         len;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      len = $urandom_range(1, 6);
      put(CMD_CHAR, ident_char(1'b1));
      for (int i = 1; i < len; i++) put(CMD_CHAR, ident_char(1'b0));
    end else if (pick < 32) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) put(CMD_CHAR, 8'(CH_ZERO + $urandom_range(0, 9)));
    end else if (pick < 45) begin
      put(CMD_CHAR, CH_QUOTE);
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          put(CMD_CHAR, CH_QUOTE);
          put(CMD_CHAR, CH_QUOTE);
        end else begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
          put(CMD_CHAR, c);
        end
      end
      case ($urandom_range(0, 9))
        7, 8: put(CMD_EOL, 8'($urandom_range(0, 255)));
        9: put(CMD_EOI, 8'($urandom_range(0, 255)));
        default: put(CMD_CHAR, CH_QUOTE);
      endcase
    end else if (pick < 55) begin
      put(CMD_CHAR, 8'($urandom_range(0, 255)));
    end else if (pick < 63) begin
      put(CMD_CHAR, CH_LBRACE);
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          put(CMD_EOL, 8'($urandom_range(0, 255)));
        end else begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_RBRACE);
          put(CMD_CHAR, c);
        end
      end
      if ($urandom_range(0, 7) == 0) put(CMD_EOI, 8'($urandom_range(0, 255)));
      else put(CMD_CHAR, CH_RBRACE);
    end else if (pick < 88) begin
      case ($urandom_range(0, 3))
        0: put(CMD_CHAR, CH_SPACE);
        1: put(CMD_CHAR, CH_TAB);
        2: put(CMD_CHAR, CH_NL);
        default: put(CMD_EOL, 8'($urandom_range(0, 255)));
      endcase
    end else if (pick < 95) begin
      put(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end else begin
      put(CMD_EOI, 8'($urandom_range(0, 255)));
    end
  endtask

  // sample handshakes, check results, predict from accepted words
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    word_taken <= s_axis_tvalid && s_axis_tready;
    result_taken <= m_axis_tvalid && m_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (tokens_due.size() == 0) begin
          report_mismatch("unexpected result", int'(m_axis_tdata), 0);
        end else begin
          want = tokens_due.pop_front();
          if (m_axis_tdata !== want.tok_char)
            report_mismatch("tok_char", int'(m_axis_tdata), int'(want.tok_char));
          if (m_axis_tuser[0] !== want.has_char)
            report_mismatch("has_char", int'(m_axis_tuser[0]), int'(want.has_char));
          if (m_axis_tuser[3:1] !== want.kind)
            report_mismatch("kind", int'(m_axis_tuser[3:1]), int'(want.kind));
          if (m_axis_tlast !== want.last)
            report_mismatch("last", int'(m_axis_tlast), int'(want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        words_in <= words_in + 1;
        scan_word(s_axis_tuser, s_axis_tdata);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || word_taken)) begin
      if (word_taken) src_gap = draw_wait(SRC);
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        next_word = pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= next_word.cmd;
        s_axis_tdata <= next_word.ch;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // hold the output off for a long stretch so that the scanner backs up
  always @(negedge clk) begin
    if (word_taken && (words_in == CHOKE_AT_A || words_in == CHOKE_AT_B)) begin
      choke_left <= CHOKE_LEN;
    end else if (choke_left != 0) begin
      choke_left <= choke_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (result_taken) snk_wait = draw_wait(SNK);
      if (choke_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    // identifier folded, closed by a high punctuation byte
    put(CMD_CHAR, CH_LO_A);
    put(CMD_CHAR, CH_UP_Z);
    put(CMD_CHAR, CH_UNDER);
    put(CMD_CHAR, CH_NINE);
    put(CMD_CHAR, 8'hFF);
    // number closed by end of line
    put(CMD_CHAR, CH_ZERO);
    put(CMD_CHAR, CH_ZERO + 8'd1);
    put(CMD_EOL, 8'h00);
    // empty string closed by a zero byte
    put(CMD_CHAR, CH_QUOTE);
    put(CMD_CHAR, CH_QUOTE);
    put(CMD_CHAR, 8'h00);
    // string with a doubled quote, cut by end of line
    put(CMD_CHAR, CH_QUOTE);
    put(CMD_CHAR, CH_LO_Z);
    put(CMD_CHAR, CH_QUOTE);
    put(CMD_CHAR, CH_QUOTE);
    put(CMD_EOL, 8'hFF);
    // comment across a line with a quote inside, then a stray closing brace
    put(CMD_CHAR, CH_LBRACE);
    put(CMD_CHAR, CH_QUOTE);
    put(CMD_EOL, 8'h55);
    put(CMD_CHAR, CH_RBRACE);
    put(CMD_CHAR, CH_RBRACE);
    put(CMD_NOP, 8'hAA);
    put(CMD_CHAR, CH_TAB);
    put(CMD_CHAR, CH_LO_A);
    put(CMD_EOI, 8'h00);
    // open comment dropped at end of input
    put(CMD_CHAR, CH_LBRACE);
    put(CMD_EOI, 8'hFF);

    random_base = words_counted;
    while (words_counted - random_base < RANDOM_WORDS) add_fragment();
    put(CMD_EOI, 8'h00);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_in != words_total || tokens_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(negedge clk);
    $display("tb: timeout after %0d cycles", cycle_count);
    $display("tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/sts_pkg.sv
design/sts_step.sv
design/sts_out.sv
design/source_token_scanner.sv
tb/sv/tb.sv
